// File: design/wlbp_pkg.sv
// Shared types and constants for the wear-levelled blank page picker.
// Holds request codes, field widths and the cell token and commit structs.
// No dependencies.
`default_nettype none

package wlbp_pkg;

   // pages covered by the flag bitmaps and the page index
   localparam int FLAG_PAGES         = 8;
   localparam int PAGE_COUNT_DEFAULT = 8;
   localparam int IDX_W              = 3;
   localparam int COUNT_W            = 16;

   // a counter at this value is saturated and never picked
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

   // request kinds
   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_CLAIM = 2'd1;
   localparam logic [1:0] REQ_PEEK  = 2'd2;
   localparam logic [1:0] REQ_FORCE = 2'd3;

   // search token handed from cell to cell
   typedef struct packed {
      logic               live;
      logic [1:0]         op;
      logic               best_ok;
      logic [COUNT_W-1:0] best_count;
      logic [IDX_W-1:0]   best_idx;
      logic               force_ok;
      logic [IDX_W-1:0]   force_idx;
   } token_type;

   // counter update broadcast to every cell at the end of a scan
   typedef struct packed {
      logic             clear;
      logic             incr;
      logic [IDX_W-1:0] idx;
   } commit_type;

endpackage

`default_nettype wire

// File: design/wear_leveled_blank_page_picker.sv
// Path: a taken request is registered as a search token, which walks SCAN = min(PAGE_COUNT, 8)
// page cells, one a cycle, and then passes the pending and output registers to rsp_tvalid.
// Requests: one at a time; the next request is taken once the
// result has moved into the output register, even while that result waits to be taken.
// Reset: synchronous, active high; all erase counters return to zero at once.
// Top level of the picker; depends on wlbp_pkg and wlbp_cell.
`default_nettype none

module wear_leveled_blank_page_picker #(
   parameter int PAGE_COUNT = wlbp_pkg::PAGE_COUNT_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [23:0] req_tdata,   // erased_flags[7:0], table_flags[7:0], fallback_page[2:0], zero
   input  wire  [1:0]  req_tuser,   // req_type[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata    // found, page_index[2:0], erase_request, zero
);

   localparam int SCAN_PAGES = (PAGE_COUNT < wlbp_pkg::FLAG_PAGES) ?
                               PAGE_COUNT : wlbp_pkg::FLAG_PAGES;
   localparam int RSP_W = 2 + wlbp_pkg::IDX_W;

   logic                            busy_ff, busy_in;
   logic [wlbp_pkg::FLAG_PAGES-1:0] erased_ff, table_ff;
   logic [wlbp_pkg::IDX_W-1:0]      fallback_ff;
   wlbp_pkg::token_type             launch_ff, launch_in;
   wlbp_pkg::token_type             tok [SCAN_PAGES+1];
   wlbp_pkg::token_type             tok_end;
   wlbp_pkg::commit_type            commit;
   logic                            pend_valid_ff, pend_valid_in;
   logic [RSP_W-1:0]                pend_data_ff, result;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]                rsp_data_ff;
   logic                            req_take, pend_move;
   logic [SCAN_PAGES:0]             live_vec;

   assign req_tready = !busy_ff;
   assign req_take   = req_tvalid && req_tready;
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   // launch a fresh token when a request is taken
   always_comb begin
      launch_in            = launch_ff;
      launch_in.live       = req_take;
      if (req_take) begin
         launch_in.op         = req_tuser;
         launch_in.best_ok    = 1'b0;
         launch_in.best_count = wlbp_pkg::COUNT_LIMIT;
         launch_in.best_idx   = '0;
         launch_in.force_ok   = 1'b0;
         launch_in.force_idx  = '0;
      end
   end

   // hold the request flags for the cells while the token walks
   always_ff @(posedge clock) begin
      if (req_take) begin
         erased_ff   <= req_tdata[7:0];
         table_ff    <= req_tdata[15:8];
         fallback_ff <= req_tdata[18:16];
      end
   end

   assign tok[0] = launch_ff;

   // chain of page cells
   for (genvar g = 0; g < SCAN_PAGES; g++) begin : g_cell
      wlbp_cell #(
         .CELL_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .erased_bit (erased_ff[g]),
         .table_bit  (table_ff[g]),
         .tok_left   (tok[g]),
         .tok_right  (tok[g+1]),
         .commit     (commit)
      );
   end

   assign tok_end = tok[SCAN_PAGES];

   // form the result and the counter update when the token leaves the chain
   always_comb begin
      result       = '0;
      commit.clear = 1'b0;
      commit.incr  = 1'b0;
      commit.idx   = tok_end.best_idx;
      unique case (tok_end.op)
         wlbp_pkg::REQ_CLEAR: begin
            commit.clear = tok_end.live;
         end
         wlbp_pkg::REQ_CLAIM: begin
            commit.incr = tok_end.live && tok_end.best_ok;
            if (tok_end.best_ok) begin
               result = {1'b0, tok_end.best_idx, 1'b1};
            end
         end
         wlbp_pkg::REQ_PEEK: begin
            if (tok_end.best_ok) begin
               result = {1'b0, tok_end.best_idx, 1'b1};
            end else begin
               result = {1'b0, fallback_ff, 1'b0};
            end
         end
         wlbp_pkg::REQ_FORCE: begin
            if (tok_end.force_ok) begin
               result = {1'b1, tok_end.force_idx, 1'b1};
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // advance pending result to the output register, release busy
   always_comb begin
      busy_in       = busy_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pend_move) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         busy_in       = 1'b0;
      end
      if (tok_end.live) begin
         pend_valid_in = 1'b1;
      end
      if (req_take) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         launch_ff.live <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         launch_ff     <= launch_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (tok_end.live) begin
         pend_data_ff <= result;
      end
      if (pend_move) begin
         rsp_data_ff <= pend_data_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-RSP_W){1'b0}}, rsp_data_ff};

   // live flags along the chain
   always_comb begin
      for (int i = 0; i <= SCAN_PAGES; i++) begin
         live_vec[i] = tok[i].live;
      end
   end

   // at most one search token in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(live_vec))
      else $error("more than one search token in the cell chain");

   // a token or pending result only exists while busy
   a_busy_cover: assert property (@(posedge clock) disable iff (reset)
      ((|live_vec) || pend_valid_ff) |-> busy_ff)
      else $error("work in flight while not busy");

   // an erase request only comes with a found page
   a_erase_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff[RSP_W-1] && !rsp_data_ff[0]))
      else $error("erase request without a found page");

   // a taken request starts a token on the next cycle
   a_launch: assert property (@(posedge clock) disable iff (reset)
      req_take |=> launch_ff.live)
      else $error("taken request did not launch a token");

endmodule

`default_nettype wire

// File: design/wlbp_cell.sv
// One page cell of the picker chain: holds the page's erase counter and
// refines the search token on its way to the next cell.
// Depends on wlbp_pkg.
`default_nettype none

module wlbp_cell #(
   parameter int CELL_INDEX = 0
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         erased_bit,
   input  wire                         table_bit,
   input  wire wlbp_pkg::token_type    tok_left,
   output wlbp_pkg::token_type         tok_right,
   input  wire wlbp_pkg::commit_type   commit
);

   localparam logic [wlbp_pkg::IDX_W-1:0] MY_IDX = wlbp_pkg::IDX_W'(CELL_INDEX);

   wlbp_pkg::token_type             tok_ff;
   wlbp_pkg::token_type             tok_in;
   logic [wlbp_pkg::COUNT_W-1:0]    count_ff;
   logic [wlbp_pkg::COUNT_W-1:0]    count_in;

   // refine the token with this page
   always_comb begin
      tok_in = tok_left;
      if (tok_left.op == wlbp_pkg::REQ_FORCE) begin
         if (!tok_left.force_ok && !table_bit) begin
            tok_in.force_ok  = 1'b1;
            tok_in.force_idx = MY_IDX;
         end
      end else if (erased_bit && (count_ff < tok_left.best_count)) begin
         tok_in.best_ok    = 1'b1;
         tok_in.best_count = count_ff;
         tok_in.best_idx   = MY_IDX;
      end
   end

   // apply the broadcast update; a picked counter is below the limit
   always_comb begin
      count_in = count_ff;
      if (commit.clear) begin
         count_in = '0;
      end else if (commit.incr && (commit.idx == MY_IDX)) begin
         count_in = count_ff + wlbp_pkg::COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
         count_ff    <= '0;
      end else begin
         tok_ff   <= tok_in;
         count_ff <= count_in;
      end
   end

   assign tok_right = tok_ff;

endmodule

`default_nettype wire
